/* rtl/core/wheel_slip_window_monitor_defines.svh */
// Assertion macros for the wheel slip window monitor checker
`ifndef WHEEL_SLIP_WINDOW_MONITOR_DEFINES_SVH
`define WHEEL_SLIP_WINDOW_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define WSW_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define WSW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/wsw_pkg.sv */
// Package: widths, constants, codes and types of the wheel slip window monitor
`default_nettype none

package wsw_pkg;

   // Ring depth and derived index and count widths
   localparam int WINDOW_DEPTH = 64;
   localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

   // Field widths
   localparam int SPEED_W   = 16;
   localparam int STAMP_W   = 32;
   localparam int RATIO_W   = 16;
   localparam int MIN_CMD_W = 15;
   localparam int TICKS_W   = 16;
   localparam int FRAC_W    = 12;
   localparam int SUM_W     = RATIO_W + CNT_W;
   localparam int ENTRY_W   = RATIO_W + STAMP_W;

   // Shared serial divider widths
   localparam int QUO_NEED_W = SPEED_W + FRAC_W;
   localparam int DIVD_W     = (SUM_W > QUO_NEED_W) ? SUM_W : QUO_NEED_W;
   localparam int DIVS_W     = (CNT_W > SPEED_W) ? CNT_W : SPEED_W;
   localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);

   // Q3.12 constants
   localparam logic signed [RATIO_W-1:0] RATIO_ONE   = RATIO_W'(1 << FRAC_W);
   localparam logic signed [RATIO_W-1:0] RATIO_FLOOR = {1'b1, {(RATIO_W-1){1'b0}}};
   // quotient above this saturates the ratio at its floor
   localparam int QUO_SAT = (1 << FRAC_W) + (1 << (RATIO_W - 1));

   // Register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CMD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd3;

   localparam logic [MIN_CMD_W-1:0]      MIN_CMD_RST   = 15'd64;
   localparam logic [TICKS_W-1:0]        GRACE_RST     = 16'd100;
   localparam logic [TICKS_W-1:0]        WINDOW_RST    = 16'd500;
   localparam logic signed [RATIO_W-1:0] THRESHOLD_RST = 16'sd2048;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_RATIO_DIV,
      ST_FULL_RD,
      ST_FULL_POP,
      ST_PUSH,
      ST_PRUNE_RD,
      ST_PRUNE_CHK,
      ST_EVAL,
      ST_MEAN_DIV,
      ST_DONE
   } state_type;

   // Divider request and response
   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

/* rtl/core/wsw_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module wsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/wsw_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module wsw_div (
   input  logic                 clock,
   input  logic                 reset,
   input  wsw_pkg::div_req_type div_req,
   output wsw_pkg::div_rsp_type div_rsp
);

   import wsw_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVS_W-1:0]    rem_ff, rem_in;
   logic [DIVS_W-1:0]    dvs_ff, dvs_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic [DIVS_W:0]      trial;
   logic [DIVS_W:0]      diff;

   // One shift-and-subtract step; dividend bits leave the top of quo as
   // quotient bits enter at the bottom
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVD_W);
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         if (!diff[DIVS_W]) begin
            rem_in = diff[DIVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

/* rtl/core/wheel_slip_window_monitor.sv */
// Top level: wheel slip window monitor with sample ring and serial divider
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  commanded_speed, measured_speed, timestamp
//   rsp      out        rsp_valid / rsp_stall  evaluating, slipping, mean_slip_ratio
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// Idle command (below the minimum magnitude): CLASSIFY goes straight to DONE.
// Active item: the sample is pushed, then at least one sample is inspected for ageing;
// the bit-serial divider makes two passes (ratio, window mean); a zero command skips the
// ratio pass and an item that is not evaluated skips the mean pass. A full ring first
// pops its oldest sample. Reset is synchronous; the ring needs no clearing pass. Input
// reopens as the result is registered; a stalled result holds the next one in DONE.
`default_nettype none

module wheel_slip_window_monitor (
   input  logic                                    clock,
   input  logic                                    reset,
   // input items
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [wsw_pkg::SPEED_W-1:0]      req_commanded_speed,
   input  logic signed [wsw_pkg::SPEED_W-1:0]      req_measured_speed,
   input  logic        [wsw_pkg::STAMP_W-1:0]      req_timestamp,
   // result items
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_evaluating,
   output logic                                    rsp_slipping,
   output logic signed [wsw_pkg::RATIO_W-1:0]      rsp_mean_slip_ratio,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [wsw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic        [wsw_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import wsw_pkg::*;

   localparam int TAIL_W = CNT_W + 1;

   state_type state_ff, state_in;

   // configuration
   logic [MIN_CMD_W-1:0]      min_cmd_ff, min_cmd_in;
   logic [TICKS_W-1:0]        grace_ff, grace_in;
   logic [TICKS_W-1:0]        window_ff, window_in;
   logic signed [RATIO_W-1:0] thr_ff, thr_in;

   // item being worked on
   logic [SPEED_W-1:0]        cmag_ff, cmag_in;
   logic [SPEED_W-1:0]        mmag_ff, mmag_in;
   logic [STAMP_W-1:0]        now_ff, now_in;
   logic signed [RATIO_W-1:0] ratio_ff, ratio_in;
   logic                      neg_ff, neg_in;

   // window state
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      active_ff, active_in;
   logic [STAMP_W-1:0]        since_ff, since_in;

   // pending result and output register
   logic                      res_eval_ff, res_eval_in;
   logic                      res_slip_ff, res_slip_in;
   logic signed [RATIO_W-1:0] res_mean_ff, res_mean_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_eval_ff, rsp_eval_in;
   logic                      rsp_slip_ff, rsp_slip_in;
   logic signed [RATIO_W-1:0] rsp_mean_ff, rsp_mean_in;

   // helpers
   logic                      below_min;
   logic                      eval_go;
   logic [STAMP_W-1:0]        elapsed;
   logic [STAMP_W-1:0]        age;
   logic                      too_old;
   logic [IDX_W-1:0]          head_next;
   logic [TAIL_W-1:0]         tail_sum;
   logic [IDX_W-1:0]          tail_idx;
   logic [SUM_W-1:0]          sum_mag;
   logic [RATIO_W:0]          ratio_diff;
   logic [RATIO_W-1:0]        quo_low;
   logic signed [SUM_W-1:0]   rd_ratio_ext;

   // ring port and divider
   logic                      ram_we;
   logic [ENTRY_W-1:0]        ram_rd_data;
   logic signed [RATIO_W-1:0] rd_ratio;
   logic [STAMP_W-1:0]        rd_stamp;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   wsw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_idx),
      .wr_data ({ratio_ff, now_ff}),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   wsw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Shared conditions and ring arithmetic
   assign rd_ratio     = ram_rd_data[ENTRY_W-1 -: RATIO_W];
   assign rd_stamp     = ram_rd_data[STAMP_W-1:0];
   assign rd_ratio_ext = {{(SUM_W-RATIO_W){rd_ratio[RATIO_W-1]}}, rd_ratio};
   assign below_min    = cmag_ff < {1'b0, min_cmd_ff};
   assign elapsed      = now_ff - since_ff;
   assign eval_go      = (elapsed >= STAMP_W'(grace_ff)) && (count_ff != '0);
   assign age          = now_ff - rd_stamp;
   assign too_old      = age > STAMP_W'(window_ff);
   assign head_next    = (head_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign sum_mag      = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign quo_low      = div_rsp.quotient[RATIO_W-1:0];
   assign ratio_diff   = {RATIO_ONE[RATIO_W-1], RATIO_ONE} - {1'b0, quo_low};

   always_comb begin
      tail_sum = TAIL_W'(head_ff) + TAIL_W'(count_ff);
      if (tail_sum >= TAIL_W'(WINDOW_DEPTH)) begin
         tail_sum = tail_sum - TAIL_W'(WINDOW_DEPTH);
      end
      tail_idx = tail_sum[IDX_W-1:0];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (below_min) begin
               state_in = ST_DONE;
            end else if (cmag_ff != '0) begin
               state_in = ST_RATIO_DIV;
            end else if (count_ff == CNT_W'(WINDOW_DEPTH)) begin
               state_in = ST_FULL_RD;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_RATIO_DIV: begin
            if (div_rsp.done) begin
               state_in = (count_ff == CNT_W'(WINDOW_DEPTH)) ? ST_FULL_RD : ST_PUSH;
            end
         end
         ST_FULL_RD:  state_in = ST_FULL_POP;
         ST_FULL_POP: state_in = ST_PUSH;
         ST_PUSH:     state_in = ST_PRUNE_RD;
         ST_PRUNE_RD: state_in = ST_PRUNE_CHK;
         ST_PRUNE_CHK: begin
            if (too_old && (count_ff != CNT_W'(1))) begin
               state_in = ST_PRUNE_RD;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = eval_go ? ST_MEAN_DIV : ST_DONE;
         end
         ST_MEAN_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs: ring write strobe and divider requests
   always_comb begin
      ram_we           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DIVD_W'({mmag_ff, {FRAC_W{1'b0}}});
      div_req.divisor  = DIVS_W'(cmag_ff);
      unique case (state_ff)
         ST_CLASSIFY: begin
            div_req.start = !below_min && (cmag_ff != '0);
         end
         ST_PUSH: begin
            ram_we = 1'b1;
         end
         ST_EVAL: begin
            div_req.start    = eval_go;
            div_req.dividend = DIVD_W'(sum_mag);
            div_req.divisor  = DIVS_W'(count_ff);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      min_cmd_in  = min_cmd_ff;
      grace_in    = grace_ff;
      window_in   = window_ff;
      thr_in      = thr_ff;
      cmag_in     = cmag_ff;
      mmag_in     = mmag_ff;
      now_in      = now_ff;
      ratio_in    = ratio_ff;
      neg_in      = neg_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      active_in   = active_ff;
      since_in    = since_ff;
      res_eval_in = res_eval_ff;
      res_slip_in = res_slip_ff;
      res_mean_in = res_mean_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_eval_in  = rsp_eval_ff;
      rsp_slip_in  = rsp_slip_ff;
      rsp_mean_in  = rsp_mean_ff;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_CMD:   min_cmd_in = csr_wdata[MIN_CMD_W-1:0];
            CSR_GRACE:     grace_in   = csr_wdata[TICKS_W-1:0];
            CSR_WINDOW:    window_in  = csr_wdata[TICKS_W-1:0];
            CSR_THRESHOLD: thr_in     = signed'(csr_wdata[RATIO_W-1:0]);
            default:       thr_in     = thr_ff;
         endcase
      end

      // result taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            cmag_in = req_commanded_speed[SPEED_W-1] ?
                      SPEED_W'(-req_commanded_speed) : SPEED_W'(req_commanded_speed);
            mmag_in = req_measured_speed[SPEED_W-1] ?
                      SPEED_W'(-req_measured_speed) : SPEED_W'(req_measured_speed);
            now_in  = req_timestamp;
         end
         ST_CLASSIFY: begin
            if (below_min) begin
               // idle command: empty the window and report zeros
               head_in     = '0;
               count_in    = '0;
               sum_in      = '0;
               active_in   = 1'b0;
               res_eval_in = 1'b0;
               res_slip_in = 1'b0;
               res_mean_in = '0;
            end else begin
               if (!active_ff) begin
                  active_in = 1'b1;
                  since_in  = now_ff;
               end
               // zero command with zero minimum
               ratio_in = (mmag_ff == '0) ? RATIO_ONE : RATIO_FLOOR;
            end
         end
         ST_RATIO_DIV: begin
            if (div_rsp.done) begin
               ratio_in = (div_rsp.quotient > DIVD_W'(QUO_SAT)) ?
                          RATIO_FLOOR : signed'(ratio_diff[RATIO_W-1:0]);
            end
         end
         ST_FULL_POP: begin
            sum_in   = sum_ff - rd_ratio_ext;
            head_in  = head_next;
            count_in = count_ff - 1'b1;
         end
         ST_PUSH: begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + {{(SUM_W-RATIO_W){ratio_ff[RATIO_W-1]}}, ratio_ff};
         end
         ST_PRUNE_CHK: begin
            if (too_old) begin
               sum_in   = sum_ff - rd_ratio_ext;
               head_in  = head_next;
               count_in = count_ff - 1'b1;
            end
         end
         ST_EVAL: begin
            neg_in      = sum_ff[SUM_W-1];
            res_eval_in = 1'b0;
            res_slip_in = 1'b0;
            res_mean_in = '0;
         end
         ST_MEAN_DIV: begin
            if (div_rsp.done) begin
               res_eval_in = 1'b1;
               res_mean_in = neg_ff ? signed'(RATIO_W'(-quo_low)) : signed'(quo_low);
               res_slip_in = (neg_ff ? signed'(RATIO_W'(-quo_low)) : signed'(quo_low))
                             >= thr_ff;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_eval_in  = res_eval_ff;
               rsp_slip_in  = res_slip_ff;
               rsp_mean_in  = res_mean_ff;
            end
         end
         default: begin
            neg_in = neg_ff;
         end
      endcase
   end

   // Control and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_cmd_ff   <= MIN_CMD_RST;
         grace_ff     <= GRACE_RST;
         window_ff    <= WINDOW_RST;
         thr_ff       <= THRESHOLD_RST;
         head_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         active_ff    <= 1'b0;
         since_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_cmd_ff   <= min_cmd_in;
         grace_ff     <= grace_in;
         window_ff    <= window_in;
         thr_ff       <= thr_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         active_ff    <= active_in;
         since_ff     <= since_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      cmag_ff     <= cmag_in;
      mmag_ff     <= mmag_in;
      now_ff      <= now_in;
      ratio_ff    <= ratio_in;
      neg_ff      <= neg_in;
      res_eval_ff <= res_eval_in;
      res_slip_ff <= res_slip_in;
      res_mean_ff <= res_mean_in;
      rsp_eval_ff <= rsp_eval_in;
      rsp_slip_ff <= rsp_slip_in;
      rsp_mean_ff <= rsp_mean_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_evaluating      = rsp_eval_ff;
   assign rsp_slipping        = rsp_slip_ff;
   assign rsp_mean_slip_ratio = rsp_mean_ff;

endmodule

`default_nettype wire

/* rtl/core/wsw_checker.sv */
// Port checker for the wheel slip window monitor, bound to the top level
`default_nettype none
`include "wheel_slip_window_monitor_defines.svh"

module wsw_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_evaluating,
   input logic                               rsp_slipping,
   input logic signed [wsw_pkg::RATIO_W-1:0] rsp_mean_slip_ratio
);

   import wsw_pkg::*;

   // a stalled result stays offered and unchanged
   `WSW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "rsp item dropped while stalled")
   `WSW_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_mean_slip_ratio) && $stable(rsp_evaluating) && $stable(rsp_slipping), "rsp payload changed while stalled")

   // not evaluating means an all-zero result
   `WSW_ASSERT_SAME(a_idle_zero, rsp_valid && !rsp_evaluating, !rsp_slipping && (rsp_mean_slip_ratio == '0), "result not zero while not evaluating")

   // a window mean never exceeds a ratio of one
   `WSW_ASSERT_SAME(a_mean_range, rsp_valid && rsp_evaluating, rsp_mean_slip_ratio <= RATIO_ONE, "mean ratio above one")

   // one item at a time: an accepted item closes the input
   `WSW_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "second item taken while busy")

endmodule

bind wheel_slip_window_monitor wsw_checker u_wsw_checker (.*);

`default_nettype wire
